// File: rtl/three_axis_pid_with_integral_clamp_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-axis PID block
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_PID_WITH_INTEGRAL_CLAMP_DEFINES_SVH
`define THREE_AXIS_PID_WITH_INTEGRAL_CLAMP_DEFINES_SVH

// same-cycle implication
`define TAPID_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tapid: same-cycle check failed");

// next-cycle implication
`define TAPID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tapid: next-cycle check failed");

`endif

// File: rtl/tapid_pkg.sv
// ----------------------------------------------------------------------------
// tapid_pkg
// Types and constants of the three-axis PID controller.
// ----------------------------------------------------------------------------
package tapid_pkg;

  localparam int unsigned ANGLE_W   = 24;
  localparam int unsigned ERR_W     = ANGLE_W + 1;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned LIMIT_W   = 23;
  localparam int unsigned DT_W      = 20;
  localparam int unsigned INTEG_W   = 24;
  localparam int unsigned DRIVE_W   = 32;
  localparam int unsigned MAX_AXES  = 3;
  localparam int unsigned AXIS_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [DT_W-1:0]   DT_DEFAULT = 20'd1049;
  localparam logic [AXIS_W-1:0] AXIS_YAW   = 2'd2;

  // derivative quotient: |de| * kd * 16 over dt
  localparam int unsigned NUM_W = ERR_W + 1 + GAIN_W + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_D     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_P_YAW = 3'd3,
    REG_GAIN_D_YAW = 3'd4,
    REG_GAIN_I_YAW = 3'd5,
    REG_INT_LIMIT  = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_P    = 3'd1,
    MUL_D    = 3'd2,
    MUL_E    = 3'd3,
    MUL_H    = 3'd4,
    MUL_L    = 3'd5
  } mul_sel_e;

  typedef struct packed {
    logic                 sample_valid;
    logic signed [23:0]   measured_pitch;
    logic signed [23:0]   measured_roll;
    logic signed [23:0]   measured_yaw;
    logic signed [23:0]   target_pitch;
    logic signed [23:0]   target_roll;
    logic signed [23:0]   target_yaw;
    logic [19:0]          interval;
  } tapid_in_t;

  typedef struct packed {
    logic signed [31:0] drive_pitch;
    logic signed [31:0] drive_roll;
    logic signed [31:0] drive_yaw;
  } tapid_out_t;

  typedef struct packed {
    logic              load;
    mul_sel_e          mul;
    logic              div_start;
    logic              do_inc;
    logic              do_int;
    logic              do_sum;
    logic              publish;
    logic [AXIS_W-1:0] axis;
  } tapid_cmd_t;

  typedef struct packed {
    logic div_busy;
  } tapid_status_t;

endpackage

// File: rtl/tapid_div.sv
// ----------------------------------------------------------------------------
// tapid_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tapid_div
  import tapid_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DT_W-1:0]  den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned STEPS = (NUM_W + 1) / 2;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DT_W-1:0]  rem_q, rem_d;
  logic [DT_W-1:0]  den_q;

  logic [DT_W:0]    r1, r2;
  logic [DT_W-1:0]  rem1;
  logic [NUM_W-1:0] quo1;

  always_comb begin
    r1   = {rem_q, quo_q[NUM_W-1]};
    rem1 = (r1 >= {1'b0, den_q}) ? DT_W'(r1 - {1'b0, den_q}) : r1[DT_W-1:0];
    quo1 = {quo_q[NUM_W-2:0], (r1 >= {1'b0, den_q})};
    r2   = {rem1, quo1[NUM_W-1]};
    rem_d = (r2 >= {1'b0, den_q}) ? DT_W'(r2 - {1'b0, den_q}) : r2[DT_W-1:0];
    quo_d = {quo1[NUM_W-2:0], (r2 >= {1'b0, den_q})};
    cnt_d = cnt_q - CNT_W'(1);
    busy_d = (cnt_q != CNT_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(STEPS);
    end else if (busy_q) begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/tapid_datapath.sv
// ----------------------------------------------------------------------------
// tapid_datapath
// Config registers, per-axis state, shared multiplier and accumulate logic.
// ----------------------------------------------------------------------------
module tapid_datapath
  import tapid_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GAIN_W-1:0]    cfg_data_i,
  input  tapid_in_t            in_data_i,
  input  tapid_cmd_t           cmd_i,
  output tapid_status_t        status_o,
  output tapid_out_t           out_data_o
);

  localparam int unsigned MA_W = ERR_W + 1;
  localparam int unsigned MP_W = MA_W + GAIN_W;
  localparam int unsigned PM_W = 33;
  localparam int unsigned IS_W = 35;
  localparam int unsigned SUM_W = NUM_W + 2;

  // configuration
  logic [GAIN_W-1:0]  gain_p_q, gain_d_q, gain_i_q;
  logic [GAIN_W-1:0]  gain_py_q, gain_dy_q, gain_iy_q;
  logic [LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= 24'd39322;
      gain_d_q  <= 24'd196608;
      gain_i_q  <= 24'd1311;
      gain_py_q <= 24'd26214;
      gain_dy_q <= 24'd0;
      gain_iy_q <= 24'd131;
      limit_q   <= 23'd204800;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_P:     gain_p_q  <= cfg_data_i;
        REG_GAIN_D:     gain_d_q  <= cfg_data_i;
        REG_GAIN_I:     gain_i_q  <= cfg_data_i;
        REG_GAIN_P_YAW: gain_py_q <= cfg_data_i;
        REG_GAIN_D_YAW: gain_dy_q <= cfg_data_i;
        REG_GAIN_I_YAW: gain_iy_q <= cfg_data_i;
        REG_INT_LIMIT:  limit_q   <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // per-axis state
  logic signed [ERR_W-1:0]   err_q   [MAX_AXES];
  logic signed [ERR_W-1:0]   prev_q  [MAX_AXES];
  logic signed [INTEG_W-1:0] integ_q [MAX_AXES];
  logic signed [DRIVE_W-1:0] last_q  [MAX_AXES];
  logic                      first_q;
  logic [DT_W-1:0]           dt_q;

  logic signed [ERR_W-1:0] err_in [MAX_AXES];

  always_comb begin
    err_in[0] = ERR_W'(in_data_i.measured_pitch) - ERR_W'(in_data_i.target_pitch);
    err_in[1] = ERR_W'(in_data_i.measured_roll) - ERR_W'(in_data_i.target_roll);
    err_in[2] = ERR_W'(in_data_i.measured_yaw) - ERR_W'(in_data_i.target_yaw);
  end

  // working registers
  logic [PM_W-1:0]     p_mag_q;
  logic [MP_W-1:0]     num_q;
  logic                dneg_q;
  logic [44:0]         edt_q;
  logic [MP_W-2:0]     hik_q;
  logic [23:0]         lok_q;
  logic [PM_W-1:0]     inc_q;

  // current axis operands
  logic signed [ERR_W-1:0] e, pv;
  logic                    eneg;
  logic [ERR_W-1:0]        emag;
  logic signed [MA_W-1:0]  de;
  logic [MA_W-1:0]         demag;
  logic                    yaw;
  logic [GAIN_W-1:0]       kp, kd, ki;
  logic [MA_W-1:0]         mul_a;
  logic [GAIN_W-1:0]       mul_b;
  logic [MP_W-1:0]         prod;

  always_comb begin
    e     = err_q[cmd_i.axis];
    pv    = prev_q[cmd_i.axis];
    eneg  = e[ERR_W-1];
    emag  = eneg ? ERR_W'(-e) : e;
    de    = MA_W'(e) - MA_W'(pv);
    demag = de[MA_W-1] ? MA_W'(-de) : de;
    yaw   = (cmd_i.axis == AXIS_YAW);
    kp    = yaw ? gain_py_q : gain_p_q;
    kd    = yaw ? gain_dy_q : gain_d_q;
    ki    = yaw ? gain_iy_q : gain_i_q;
    case (cmd_i.mul)
      MUL_P:   begin mul_a = {1'b0, emag};              mul_b = kp;                end
      MUL_D:   begin mul_a = demag;                     mul_b = kd;                end
      MUL_E:   begin mul_a = {1'b0, emag};              mul_b = {4'b0, dt_q};      end
      MUL_H:   begin mul_a = {1'b0, edt_q[44:20]};      mul_b = ki;                end
      MUL_L:   begin mul_a = {6'b0, edt_q[19:0]};       mul_b = ki;                end
      default: begin mul_a = '0;                        mul_b = '0;                end
    endcase
    prod = MP_W'(mul_a) * MP_W'(mul_b);
  end

  // derivative divider
  logic [NUM_W-1:0] quo;

  tapid_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  ({num_q, 4'b0}),
    .den_i  (dt_q),
    .busy_o (status_o.div_busy),
    .quo_o  (quo)
  );

  // integral update and output sum
  logic [MP_W-1:0]          inc_sum;
  logic signed [IS_W-1:0]   isum, lim_s;
  logic signed [INTEG_W-1:0] isum_c;
  logic signed [SUM_W-1:0]  p_s, d_s, total;
  logic signed [DRIVE_W-1:0] drive;

  always_comb begin
    inc_sum = MP_W'(hik_q) + MP_W'(lok_q);
    lim_s   = IS_W'(limit_q);
    isum    = eneg ? (IS_W'(integ_q[cmd_i.axis]) - IS_W'(inc_q))
                   : (IS_W'(integ_q[cmd_i.axis]) + IS_W'(inc_q));
    if (isum > lim_s) begin
      isum_c = INTEG_W'(lim_s);
    end else if (isum < -lim_s) begin
      isum_c = INTEG_W'(-lim_s);
    end else begin
      isum_c = INTEG_W'(isum);
    end
    p_s   = eneg ? -SUM_W'(p_mag_q) : SUM_W'(p_mag_q);
    d_s   = dneg_q ? -SUM_W'(quo) : SUM_W'(quo);
    total = p_s + d_s + SUM_W'(integ_q[cmd_i.axis]);
    if (total > SUM_W'(signed'({1'b0, {(DRIVE_W-1){1'b1}}}))) begin
      drive = {1'b0, {(DRIVE_W-1){1'b1}}};
    end else if (total < -SUM_W'(signed'({1'b0, 1'b1, {(DRIVE_W-1){1'b0}}}))) begin
      drive = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive = DRIVE_W'(total);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      for (int a = 0; a < MAX_AXES; a++) begin
        prev_q[a]  <= '0;
        integ_q[a] <= '0;
        last_q[a]  <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        first_q <= 1'b0;
        if (first_q) begin
          for (int a = 0; a < MAX_AXES; a++) prev_q[a] <= err_in[a];
        end
      end
      if (cmd_i.do_int) integ_q[cmd_i.axis] <= isum_c;
      if (cmd_i.do_sum) begin
        last_q[cmd_i.axis] <= drive;
        prev_q[cmd_i.axis] <= e;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int a = 0; a < MAX_AXES; a++) err_q[a] <= err_in[a];
      dt_q <= (in_data_i.interval == '0) ? DT_DEFAULT : in_data_i.interval;
    end
    case (cmd_i.mul)
      MUL_P: p_mag_q <= prod[48:16];
      MUL_D: begin
        num_q  <= prod;
        dneg_q <= de[MA_W-1];
      end
      MUL_E: edt_q <= prod[44:0];
      MUL_H: hik_q <= prod[MP_W-2:0];
      MUL_L: lok_q <= prod[43:20];
      default: ;
    endcase
    if (cmd_i.do_inc) inc_q <= inc_sum[48:16];
    if (cmd_i.publish) begin
      out_data_o.drive_pitch <= last_q[0];
      out_data_o.drive_roll  <= last_q[1];
      out_data_o.drive_yaw   <= last_q[2];
    end
  end

endmodule

// File: rtl/tapid_ctrl.sv
// ----------------------------------------------------------------------------
// tapid_ctrl
// Sequencer: walks the axes through multiply, divide and accumulate steps.
// ----------------------------------------------------------------------------
`include "three_axis_pid_with_integral_clamp_defines.svh"

module tapid_ctrl
  import tapid_pkg::*;
#(
  parameter int unsigned AXIS_COUNT = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          sample_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  tapid_status_t status_i,
  output tapid_cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MUL_P = 11'b00000000010,
    S_MUL_D = 11'b00000000100,
    S_MUL_E = 11'b00000001000,
    S_MUL_H = 11'b00000010000,
    S_MUL_L = 11'b00000100000,
    S_INC   = 11'b00001000000,
    S_INT   = 11'b00010000000,
    S_WAIT  = 11'b00100000000,
    S_SUM   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXIS_COUNT - 1);

  state_e            state_q, state_d;
  logic [AXIS_W-1:0] axis_q, axis_d;
  logic              out_valid_q, out_valid_d;
  logic              accept, publish;

  always_comb begin
    accept      = in_valid_i && (state_q == S_IDLE);
    publish     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
    state_d     = state_q;
    axis_d      = axis_q;
    out_valid_d = publish ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    case (state_q)
      S_IDLE: begin
        axis_d = '0;
        if (accept) state_d = sample_valid_i ? S_MUL_P : S_DONE;
      end
      S_MUL_P: state_d = S_MUL_D;
      S_MUL_D: state_d = S_MUL_E;
      S_MUL_E: state_d = S_MUL_H;
      S_MUL_H: state_d = S_MUL_L;
      S_MUL_L: state_d = S_INC;
      S_INC:   state_d = S_INT;
      S_INT:   state_d = S_WAIT;
      S_WAIT:  if (!status_i.div_busy) state_d = S_SUM;
      S_SUM: begin
        if (axis_q == LAST_AXIS) begin
          state_d = S_DONE;
        end else begin
          axis_d  = axis_q + AXIS_W'(1);
          state_d = S_MUL_P;
        end
      end
      S_DONE:  if (publish) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o.load      = accept && sample_valid_i;
    cmd_o.div_start = (state_q == S_MUL_E);
    cmd_o.do_inc    = (state_q == S_INC);
    cmd_o.do_int    = (state_q == S_INT);
    cmd_o.do_sum    = (state_q == S_SUM);
    cmd_o.publish   = publish;
    cmd_o.axis      = axis_q;
    case (state_q)
      S_MUL_P: cmd_o.mul = MUL_P;
      S_MUL_D: cmd_o.mul = MUL_D;
      S_MUL_E: cmd_o.mul = MUL_E;
      S_MUL_H: cmd_o.mul = MUL_H;
      S_MUL_L: cmd_o.mul = MUL_L;
      default: cmd_o.mul = MUL_NONE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // divider must be finished before the item ends or the sum is taken
  `TAPID_ASSERT_IMPL(a_div_idle, state_q == S_IDLE || state_q == S_DONE, !status_i.div_busy)
  `TAPID_ASSERT_IMPL(a_sum_div_done, state_q == S_SUM, !status_i.div_busy)
  `TAPID_ASSERT_IMPL(a_axis_range, state_q != S_IDLE, axis_q <= LAST_AXIS)
  `TAPID_ASSERT_NEXT(a_start_busy, state_q == S_MUL_E, status_i.div_busy)

endmodule

// File: rtl/three_axis_pid_with_integral_clamp.sv
// A timeout item goes straight to its result; a sample walks all
// AXIS_COUNT axes in turn. Items are taken one at a time.
// Per axis the sequencer waits on the radix-4 derivative divider.
// A finished result waits in the output register while the next item runs.
// Reset: gains and limit take their defaults, state clears, first sample armed.
// ----------------------------------------------------------------------------
// three_axis_pid_with_integral_clamp
// Three-axis PID controller with clamped integral, fixed point.
// ----------------------------------------------------------------------------
module three_axis_pid_with_integral_clamp
  import tapid_pkg::*;
#(
  parameter int unsigned AXIS_COUNT = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GAIN_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tapid_in_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tapid_out_t           out_data_o
);

  tapid_cmd_t    cmd;
  tapid_status_t status;

  tapid_ctrl #(
    .AXIS_COUNT(AXIS_COUNT)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .sample_valid_i(in_data_i.sample_valid),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  tapid_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_data_o(out_data_o)
  );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID controller bench
// Drives sample and timeout transactions with random gaps, mirrors the PID
// arithmetic per axis and checks every drive result against the prediction.
// ----------------------------------------------------------------------------
module tb_top
  import tapid_pkg::*;
();

  class drive_scoreboard;
    logic [23:0] kp, kd, ki, kp_yaw, kd_yaw, ki_yaw;
    logic [22:0] limit;
    longint prev_err [3];
    longint integ [3];
    longint last_out [3];
    bit     first;
    tapid_out_t pending [$];
    int     errors;

    function void reset_state();
      kp = 24'd39322; kd = 24'd196608; ki = 24'd1311;
      kp_yaw = 24'd26214; kd_yaw = 24'd0; ki_yaw = 24'd131;
      limit = 23'd204800;
      foreach (prev_err[a]) begin
        prev_err[a] = 0; integ[a] = 0; last_out[a] = 0;
      end
      first = 1;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [23:0] val);
      case (idx)
        REG_GAIN_P:     kp = val;
        REG_GAIN_D:     kd = val;
        REG_GAIN_I:     ki = val;
        REG_GAIN_P_YAW: kp_yaw = val;
        REG_GAIN_D_YAW: kd_yaw = val;
        REG_GAIN_I_YAW: ki_yaw = val;
        REG_INT_LIMIT:  limit = val[22:0];
        default: ;
      endcase
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    // the integral product can pass 64 bits, so use wide unsigned math
    function void note_sample(tapid_in_t s);
      longint err [3];
      longint e, de, p, d, isum;
      logic [19:0] dt;
      logic [127:0] num, prod, inc;
      logic [63:0] k_p, k_d, k_i;
      tapid_out_t r;
      if (s.sample_valid) begin
        dt = (s.interval == 0) ? DT_DEFAULT : s.interval;
        err[0] = longint'(s.measured_pitch) - longint'(s.target_pitch);
        err[1] = longint'(s.measured_roll) - longint'(s.target_roll);
        err[2] = longint'(s.measured_yaw) - longint'(s.target_yaw);
        if (first) begin
          foreach (err[a]) prev_err[a] = err[a];
          first = 0;
        end
        for (int a = 0; a < 3; a++) begin
          k_p = (a == 2) ? kp_yaw : kp;
          k_d = (a == 2) ? kd_yaw : kd;
          k_i = (a == 2) ? ki_yaw : ki;
          e = err[a];
          p = longint'((128'(mag(e)) * k_p) >> 16);
          if (e < 0) p = -p;
          de = e - prev_err[a];
          num = 128'(mag(de)) * k_d * 16;
          d = longint'(num / dt);
          if (de < 0) d = -d;
          prod = 128'(mag(e)) * dt;
          inc = (prod * k_i) >> 36;
          isum = integ[a] + ((e < 0) ? -longint'(inc) : longint'(inc));
          isum = sat(isum, -longint'(limit), longint'(limit));
          integ[a] = isum;
          last_out[a] = sat(p + d + isum, -64'sd2147483648, 64'sd2147483647);
          prev_err[a] = e;
        end
      end
      r.drive_pitch = last_out[0][31:0];
      r.drive_roll  = last_out[1][31:0];
      r.drive_yaw   = last_out[2][31:0];
      pending.push_back(r);
    endfunction

    function void check_drive(tapid_out_t got);
      tapid_out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.drive_pitch !== want.drive_pitch) begin
        $error("drive_pitch: exp %0d got %0d", want.drive_pitch, got.drive_pitch);
        errors++;
      end
      if (got.drive_roll !== want.drive_roll) begin
        $error("drive_roll: exp %0d got %0d", want.drive_roll, got.drive_roll);
        errors++;
      end
      if (got.drive_yaw !== want.drive_yaw) begin
        $error("drive_yaw: exp %0d got %0d", want.drive_yaw, got.drive_yaw);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [GAIN_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 0, in_ready_o;
  tapid_in_t in_data_i = '0;
  logic out_valid_o, out_ready_i = 0;
  tapid_out_t out_data_o;
  drive_scoreboard sb;
  bit stim_done = 0;
  bit rx_stall = 0;

  always #10 clk_i = ~clk_i;

  three_axis_pid_with_integral_clamp dut (.*);

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 120);
  endfunction

  task automatic write_cfg(cfg_reg_e idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // idle: all results in, then slack for a trailing computation
  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // valid stays up across a zero gap; it drops only for an idle stretch
  task automatic send(tapid_in_t s, bit no_gap = 0);
    int g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1; in_data_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
  endtask

  function automatic logic [23:0] rnd_angle(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 8000)) - 4000);
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  function automatic tapid_in_t rnd_sample();
    tapid_in_t s;
    int m = $urandom_range(0, 9);
    int mode = m < 2 ? 0 : (m < 3 ? 2 : (m < 6 ? 1 : 3));
    s.sample_valid = ($urandom_range(0, 9) != 0);
    s.measured_pitch = rnd_angle(mode); s.target_pitch = rnd_angle(mode);
    s.measured_roll = rnd_angle(mode);  s.target_roll = rnd_angle(mode);
    s.measured_yaw = rnd_angle(mode);   s.target_yaw = rnd_angle(mode);
    case ($urandom_range(0, 5))
      0: s.interval = '0;
      1: s.interval = 20'($urandom);
      2: s.interval = 20'($urandom_range(1, 16));
      default: s.interval = 20'($urandom_range(500, 20000));
    endcase
    return s;
  endfunction

  task automatic rnd_config(int kind);
    logic [23:0] v;
    for (int r = 0; r <= REG_INT_LIMIT; r++) begin
      case (kind)
        0: v = 24'hFFFFFF;
        1: v = '0;
        default: v = $urandom_range(0, 3) == 0 ? 24'($urandom)
                                                : 24'($urandom_range(0, 400000));
      endcase
      write_cfg(cfg_reg_e'(r), v);
    end
  endtask

  initial begin
    tapid_in_t s;
    sb = new();
    sb.reset_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);
    // directed: timeout before any sample, extremes, zero and full interval
    s = '0;
    send(s);
    s.sample_valid = 1; s.interval = '0;
    s.measured_pitch = 24'sd4096; s.target_roll = -24'sd4096;
    send(s);
    s.measured_pitch = 24'h7FFFFF; s.target_pitch = 24'h800000;
    s.measured_roll = 24'h800000; s.target_roll = 24'h7FFFFF;
    s.measured_yaw = 24'h7FFFFF; s.target_yaw = 24'h800000; s.interval = 20'hFFFFF;
    send(s);
    s.interval = 20'd1;
    send(s);
    s.sample_valid = 0;
    send(s);
    drain();
    rnd_config(0);
    s.sample_valid = 1;
    send(s);
    s.measured_pitch = 24'h800000; s.target_pitch = 24'h7FFFFF; s.interval = '0;
    send(s);
    s.measured_yaw = 24'sd0; s.target_yaw = 24'sd0; s.interval = 20'd1;
    send(s);
    drain();
    rnd_config(1);
    send(s);
    send(rnd_sample());
    drain();
    for (int ph = 0; ph < 7; ph++) begin
      rnd_config(2);
      for (int i = 0; i < 250; i++) send(rnd_sample(), i < 20);
      drain();
    end
    stim_done = 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_drive(out_data_o);
      out_ready_i <= !rx_stall && ($urandom_range(0, 99) < 70);
    end
  end

  // long receiver stall now and then
  initial begin
    forever begin
      #($urandom_range(20000, 200000));
      if (!stim_done) begin
        force_stall();
      end else begin
        @(posedge clk_i);
      end
    end
  end

  task automatic force_stall();
    @(posedge clk_i);
    rx_stall <= 1;
    repeat ($urandom_range(50, 150)) @(posedge clk_i);
    rx_stall <= 0;
  endtask

  initial begin
    wait (stim_done);
    if (sb.pending.size() != 0) sb.errors++;
    if (sb.errors == 0) $display("[three_axis_pid_with_integral_clamp] OK");
    else $display("[three_axis_pid_with_integral_clamp] ERROR");
    $finish;
  end

  initial begin
    #50ms;
    $display("[three_axis_pid_with_integral_clamp] ERROR");
    $finish;
  end
endmodule
